// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, codes and helpers for the programmable interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_REQUEST = 3'd2,
    ACT_ACK     = 3'd3,
    ACT_RESET   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_OCW  = 2'd0,
    MODE_ICW2 = 2'd1,
    MODE_ICW3 = 2'd2,
    MODE_ICW4 = 2'd3
  } mode_t;

  localparam logic [7:0] VEC_BASE_MASK = 8'hf8;
  localparam logic [7:0] MASK_ALL      = 8'hff;

  localparam int CMD_ICW1_BIT  = 4;
  localparam int CMD_OCW3_BIT  = 3;
  localparam int CMD_EOI_BIT   = 5;
  localparam int CMD_SPEC_BIT  = 6;
  localparam int OCW3_RR_BIT   = 1;
  localparam int OCW3_RIS_BIT  = 0;
  localparam int ICW1_SNGL_BIT = 1;
  localparam int ICW1_IC4_BIT  = 0;
  localparam int ICW4_AEOI_BIT = 1;

  typedef struct packed {
    logic [2:0] action;
    logic       addr_bit;
    logic [7:0] data;
    logic [2:0] irq_line;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] vector;
    logic       vector_valid;
    logic       irq_raised;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } pick_t;

  function automatic pick_t lowest_set(input logic [7:0] v);
    pick_t p;
    p = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = 3'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/pic_if.sv =====
// ----------------------------------------------------------------------------
// pic_req_if / pic_rsp_if
// Valid/ready channels carrying controller requests and their results.
// ----------------------------------------------------------------------------
interface pic_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       addr_bit;
  logic [7:0] data;
  logic [2:0] irq_line;

  modport source (output valid, action, addr_bit, data, irq_line, input ready);
  modport sink (input valid, action, addr_bit, data, irq_line, output ready);
endinterface

interface pic_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [7:0] vector;
  logic       vector_valid;
  logic       irq_raised;

  modport source (output valid, read_data, read_valid, vector, vector_valid, irq_raised,
                  input ready);
  modport sink (input valid, read_data, read_valid, vector, vector_valid, irq_raised,
                output ready);
endinterface

// ===== rtl/programmable_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// programmable_interrupt_controller
// Simplified 8259-style interrupt controller with request/result channels.
//
// A request on req carries one action: register write, register read,
// interrupt line request, acknowledge or controller reset. Each request
// gives exactly one result on rsp: read data, acknowledge vector and a flag
// that marks a new interrupt entering service.
// cfg_we/cfg_wdata set the master bit; write it only while the block is idle.
// Path: a request accepted on req goes to the input register, then its
// result goes to the result register and is shown on rsp.
// Throughput: one request per cycle while rsp is not stalled; the state
// update for a request is done between the input and result registers.
// A stalled rsp holds its result; the input register still takes one more
// request, then req.ready drops until rsp drains.
// Reset: clears both stages, restores the power-up controller state and
// sets the master bit.
// ----------------------------------------------------------------------------
module programmable_interrupt_controller
  import pic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  pic_req_if.sink   req,
  pic_rsp_if.source rsp
);

  logic    in_full;
  item_t   item_q;
  logic    out_full;
  result_t res_q;
  result_t result;
  logic    is_master;
  logic    adv;

  assign adv       = in_full && (!out_full || rsp.ready);
  assign req.ready = !in_full || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_full  <= 1'b0;
      is_master <= 1'b1;
    end else begin
      if (req.valid && req.ready) begin
        in_full <= 1'b1;
      end else if (adv) begin
        in_full <= 1'b0;
      end
      if (adv) begin
        out_full <= 1'b1;
      end else if (rsp.ready) begin
        out_full <= 1'b0;
      end
      if (cfg_we) begin
        is_master <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_q <= '{action: req.action, addr_bit: req.addr_bit, data: req.data,
                  irq_line: req.irq_line};
    end
    if (adv) begin
      res_q <= result;
    end
  end

  pic_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .item      (item_q),
    .is_master (is_master),
    .result    (result)
  );

  assign rsp.valid        = out_full;
  assign rsp.read_data    = res_q.read_data;
  assign rsp.read_valid   = res_q.read_valid;
  assign rsp.vector       = res_q.vector;
  assign rsp.vector_valid = res_q.vector_valid;
  assign rsp.irq_raised   = res_q.irq_raised;

endmodule

// ===== rtl/pic_core.sv =====
// ----------------------------------------------------------------------------
// pic_core
// Controller state and the combinational update for one request.
// ----------------------------------------------------------------------------
module pic_core
  import pic_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  logic    is_master,
  output result_t result
);

  mode_t      mode, mode_next;
  logic [7:0] icw1, icw1_next;
  logic [7:0] base, base_next;
  logic [7:0] cascade, cascade_next;
  logic [7:0] icw4, icw4_next;
  logic [7:0] mask, mask_next;
  logic [7:0] irr, irr_next;
  logic [7:0] isr, isr_next;
  logic [2:0] cur_line, cur_line_next;
  logic [7:0] cur_vec, cur_vec_next;
  logic       cur_ok, cur_ok_next;
  logic       stat_pend, stat_pend_next;
  logic [7:0] stat_byte, stat_byte_next;

  logic [7:0] req_a, isr_a;
  logic       do_try;
  pick_t      eoi_pick, try_pick;

  always_comb begin
    mode_next      = mode;
    icw1_next      = icw1;
    base_next      = base;
    cascade_next   = cascade;
    icw4_next      = icw4;
    mask_next      = mask;
    cur_line_next  = cur_line;
    cur_vec_next   = cur_vec;
    cur_ok_next    = cur_ok;
    stat_pend_next = stat_pend;
    stat_byte_next = stat_byte;
    req_a          = irr;
    isr_a          = isr;
    do_try         = 1'b0;
    eoi_pick       = '0;
    result         = '0;

    unique case (action_t'(item.action))
      ACT_WRITE: begin
        if (item.addr_bit) begin
          unique case (mode)
            MODE_OCW: mask_next = item.data;
            MODE_ICW2: begin
              base_next = item.data;
              if (icw1[ICW1_SNGL_BIT]) begin
                cascade_next = '0;
                mode_next    = icw1[ICW1_IC4_BIT] ? MODE_ICW4 : MODE_OCW;
              end else begin
                mode_next = MODE_ICW3;
              end
            end
            MODE_ICW3: begin
              cascade_next = item.data;
              mode_next    = icw1[ICW1_IC4_BIT] ? MODE_ICW4 : MODE_OCW;
            end
            MODE_ICW4: begin
              icw4_next = item.data;
              mode_next = MODE_OCW;
            end
          endcase
        end else if (item.data[CMD_ICW1_BIT]) begin
          icw1_next = item.data;
          mode_next = MODE_ICW2;
        end else if (item.data[CMD_OCW3_BIT]) begin
          if (item.data[OCW3_RR_BIT]) begin
            stat_pend_next = 1'b1;
            stat_byte_next = item.data[OCW3_RIS_BIT] ? isr : irr;
          end
        end else if (item.data[CMD_EOI_BIT]) begin
          if (item.data[CMD_SPEC_BIT]) begin
            isr_a[item.data[2:0]] = 1'b0;
            req_a[item.data[2:0]] = 1'b0;
            do_try                = 1'b1;
          end else begin
            eoi_pick = lowest_set(isr);
            if (eoi_pick.found) begin
              isr_a[eoi_pick.idx] = 1'b0;
              req_a[eoi_pick.idx] = 1'b0;
              do_try              = 1'b1;
            end
          end
        end
      end
      ACT_READ: begin
        if (item.addr_bit && mode == MODE_OCW) begin
          result.read_valid = 1'b1;
          if (stat_pend) begin
            stat_pend_next   = 1'b0;
            result.read_data = stat_byte;
          end else begin
            result.read_data = mask;
          end
        end
      end
      ACT_REQUEST: begin
        if (!mask[item.irq_line]) begin
          req_a[item.irq_line] = 1'b1;
          do_try               = 1'b1;
        end
      end
      ACT_ACK: begin
        result.vector       = cur_vec;
        result.vector_valid = cur_ok;
        if (icw4[ICW4_AEOI_BIT]) begin
          isr_a[cur_line] = 1'b0;
          req_a[cur_line] = 1'b0;
          do_try          = 1'b1;
        end
      end
      ACT_RESET: begin
        req_a     = '0;
        isr_a     = '0;
        mask_next = MASK_ALL;
      end
      default: ;
    endcase

    try_pick = lowest_set(req_a);
    if (do_try && isr_a == '0 && try_pick.found) begin
      isr_a[try_pick.idx] = 1'b1;
      cur_line_next       = try_pick.idx;
      if (is_master && cascade[try_pick.idx]) begin
        cur_vec_next = '0;
        cur_ok_next  = 1'b0;
      end else begin
        cur_vec_next = (base & VEC_BASE_MASK) | {5'b0, try_pick.idx};
        cur_ok_next  = 1'b1;
      end
      result.irq_raised = 1'b1;
    end
  end

  assign irr_next = req_a;
  assign isr_next = isr_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_OCW;
      icw1      <= '0;
      base      <= '0;
      cascade   <= '0;
      icw4      <= '0;
      mask      <= MASK_ALL;
      irr       <= '0;
      isr       <= '0;
      cur_line  <= '0;
      cur_vec   <= '0;
      cur_ok    <= 1'b1;
      stat_pend <= 1'b0;
      stat_byte <= '0;
    end else if (step) begin
      mode      <= mode_next;
      icw1      <= icw1_next;
      base      <= base_next;
      cascade   <= cascade_next;
      icw4      <= icw4_next;
      mask      <= mask_next;
      irr       <= irr_next;
      isr       <= isr_next;
      cur_line  <= cur_line_next;
      cur_vec   <= cur_vec_next;
      cur_ok    <= cur_ok_next;
      stat_pend <= stat_pend_next;
      stat_byte <= stat_byte_next;
    end
  end

endmodule

// ===== rtl/pic_checker.sv =====
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks for the programmable interrupt controller.
// ----------------------------------------------------------------------------
module pic_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       read_valid,
  input logic [7:0] vector,
  input logic       vector_valid,
  input logic       irq_raised
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(vector))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_read_or_vec: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && vector_valid))
    else $error("read and vector both valid");

  a_read_no_raise: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> !irq_raised)
    else $error("read raised an interrupt");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_data == 8'h00)
    else $error("read data without read");

endmodule

bind programmable_interrupt_controller pic_checker u_pic_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .read_data    (rsp.read_data),
  .read_valid   (rsp.read_valid),
  .vector       (rsp.vector),
  .vector_valid (rsp.vector_valid),
  .irq_raised   (rsp.irq_raised)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the programmable interrupt controller. A driver
// replays queued requests, and a bit-exact predictor of the controller forms
// the expected result of each accepted request. A monitor checks every
// result against that prediction. The run covers directed corner cases,
// then random phases with idle and stall mixes, a long receiver hold-off,
// and both settings of the master bit.
// ----------------------------------------------------------------------------
module tb_top;
  import pic_pkg::*;

  localparam int PHASE_ITEMS   = 325;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  pic_req_if req_if ();
  pic_rsp_if rsp_if ();

  programmable_interrupt_controller u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // controller shadow state
  logic       dev_master;
  mode_t      init_st;
  logic [7:0] icw1_q;
  logic [7:0] vbase_q;
  logic [7:0] casc_q;
  logic [7:0] icw4_q;
  logic [7:0] imr;
  logic [7:0] irr;
  logic [7:0] isr;
  logic [2:0] cur_irq;
  logic [7:0] cur_vec;
  logic       cur_vec_ok;
  logic       st_pend;
  logic [7:0] st_byte;

  item_t   pending_reqs[$];
  result_t results_due[$];

  int   errors      = 0;
  int   n_queued    = 0;
  int   n_req       = 0;
  int   n_rsp       = 0;
  int   n_raised    = 0;
  int   n_cascaded  = 0;
  int   quiet_cycles = 0;
  int   hold_count;
  int   src_pct;
  int   snk_pct;
  logic press_on;
  logic hold_off;

  function automatic logic grant_lowest();
    logic hit;
    hit = 1'b0;
    if (isr == 8'h00) begin
      for (int n = 0; n < 8; n++) begin
        if (!hit && irr[n]) begin
          hit     = 1'b1;
          cur_irq = 3'(n);
          isr[n]  = 1'b1;
          if (dev_master && casc_q[n]) begin
            cur_vec    = 8'h00;
            cur_vec_ok = 1'b0;
          end else begin
            cur_vec    = (vbase_q & VEC_BASE_MASK) | 8'(n);
            cur_vec_ok = 1'b1;
          end
        end
      end
    end
    return hit;
  endfunction

  function automatic logic retire_irq(input logic [2:0] line, input logic any);
    logic [2:0] ln;
    logic       hit;
    ln  = line;
    hit = !any;
    if (any) begin
      for (int n = 7; n >= 0; n--) begin
        if (isr[n]) begin
          ln  = 3'(n);
          hit = 1'b1;
        end
      end
    end
    if (!hit) return 1'b0;
    isr[ln] = 1'b0;
    irr[ln] = 1'b0;
    return grant_lowest();
  endfunction

  function automatic logic port_write(input logic port, input logic [7:0] d);
    logic raised;
    raised = 1'b0;
    if (port) begin
      case (init_st)
        MODE_OCW: imr = d;
        MODE_ICW2: begin
          vbase_q = d;
          if (icw1_q[ICW1_SNGL_BIT]) begin
            casc_q  = 8'h00;
            init_st = icw1_q[ICW1_IC4_BIT] ? MODE_ICW4 : MODE_OCW;
          end else begin
            init_st = MODE_ICW3;
          end
        end
        MODE_ICW3: begin
          casc_q  = d;
          init_st = icw1_q[ICW1_IC4_BIT] ? MODE_ICW4 : MODE_OCW;
        end
        default: begin
          icw4_q  = d;
          init_st = MODE_OCW;
        end
      endcase
    end else if (d[CMD_ICW1_BIT]) begin
      icw1_q  = d;
      init_st = MODE_ICW2;
    end else if (d[CMD_OCW3_BIT]) begin
      if (d[OCW3_RR_BIT]) begin
        st_pend = 1'b1;
        st_byte = d[OCW3_RIS_BIT] ? isr : irr;
      end
    end else if (d[CMD_EOI_BIT]) begin
      raised = retire_irq(d[2:0], !d[CMD_SPEC_BIT]);
    end
    return raised;
  endfunction

  function automatic result_t predict_item(input item_t it);
    result_t    r;
    logic [7:0] line_bit;
    r = '0;
    case (it.action)
      ACT_WRITE: r.irq_raised = port_write(it.addr_bit, it.data);
      ACT_READ: begin
        if (it.addr_bit && init_st == MODE_OCW) begin
          r.read_valid = 1'b1;
          if (st_pend) begin
            st_pend     = 1'b0;
            r.read_data = st_byte;
          end else begin
            r.read_data = imr;
          end
        end
      end
      ACT_REQUEST: begin
        line_bit = (8'h01 << it.irq_line) & ~imr;
        if (line_bit != 8'h00) begin
          irr          = irr | line_bit;
          r.irq_raised = grant_lowest();
        end
      end
      ACT_ACK: begin
        r.vector       = cur_vec;
        r.vector_valid = cur_vec_ok;
        if (!cur_vec_ok) n_cascaded++;
        if (icw4_q[ICW4_AEOI_BIT]) r.irq_raised = retire_irq(cur_irq, 1'b0);
      end
      ACT_RESET: begin
        irr = 8'h00;
        isr = 8'h00;
        imr = MASK_ALL;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_item(input logic [2:0] act, input logic port, input logic [7:0] d,
                           input logic [2:0] ln);
    item_t it;
    it.action   = act;
    it.addr_bit = port;
    it.data     = d;
    it.irq_line = ln;
    pending_reqs.push_back(it);
    n_queued++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      errors++;
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || results_due.size() != 0 || req_if.valid)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_master(input logic v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    dev_master = v;
  endtask

  task automatic run_phase(input int src, input int snk, input logic master, input logic press);
    int         target;
    int         pick;
    logic [7:0] d;
    logic [7:0] w1;
    set_master(master);
    @(posedge clk);
    src_pct  <= src;
    snk_pct  <= snk;
    press_on <= press;
    @(negedge clk);
    target = n_queued + PHASE_ITEMS;
    while (n_queued < target) begin
      pick = $urandom_range(99);
      d    = 8'($urandom);
      if (pick < 8) begin
        w1 = d | 8'h10;
        push_item(ACT_WRITE, 1'b0, w1, 3'($urandom));
        push_item(ACT_WRITE, 1'b1, 8'($urandom), 3'($urandom));
        if (!w1[ICW1_SNGL_BIT])
          push_item(ACT_WRITE, 1'b1, 8'($urandom) & 8'($urandom), 3'($urandom));
        if (w1[ICW1_IC4_BIT])
          push_item(ACT_WRITE, 1'b1, 8'($urandom), 3'($urandom));
        push_item(ACT_WRITE, 1'b1, 8'($urandom) & 8'($urandom), 3'($urandom));
      end else if (pick < 18) begin
        push_item(ACT_WRITE, 1'b1, $urandom_range(1) ? 8'h00 : d & 8'($urandom), 3'($urandom));
      end else if (pick < 45) begin
        push_item(ACT_REQUEST, 1'($urandom), d, 3'($urandom));
      end else if (pick < 60) begin
        push_item(ACT_ACK, 1'($urandom), d, 3'($urandom));
      end else if (pick < 72) begin
        push_item(ACT_WRITE, 1'b0, (d & 8'h87) | ($urandom_range(1) ? 8'h60 : 8'h20),
                  3'($urandom));
      end else if (pick < 80) begin
        push_item(ACT_WRITE, 1'b0, (d & 8'he7) | 8'h08, 3'($urandom));
        push_item(ACT_READ, 1'b1, 8'($urandom), 3'($urandom));
      end else if (pick < 88) begin
        push_item(ACT_READ, 1'($urandom), d, 3'($urandom));
      end else if (pick < 91) begin
        push_item(ACT_RESET, 1'($urandom), d, 3'($urandom));
        push_item(ACT_WRITE, 1'b1, 8'($urandom) & 8'($urandom), 3'($urandom));
      end else begin
        push_item(3'($urandom_range(7)), 1'($urandom), d, 3'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin : drive_req
    item_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        nxt.action   = req_if.action;
        nxt.addr_bit = req_if.addr_bit;
        nxt.data     = req_if.data;
        nxt.irq_line = req_if.irq_line;
        results_due.push_back(predict_item(nxt));
        n_req++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_pct) begin
          nxt = pending_reqs.pop_front();
          req_if.valid    <= 1'b1;
          req_if.action   <= nxt.action;
          req_if.addr_bit <= nxt.addr_bit;
          req_if.data     <= nxt.data;
          req_if.irq_line <= nxt.irq_line;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_rsp
    result_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_rsp++;
        if (results_due.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("read_data", want.read_data, rsp_if.read_data);
          check_field("read_valid", 8'(want.read_valid), 8'(rsp_if.read_valid));
          check_field("vector", want.vector, rsp_if.vector);
          check_field("vector_valid", 8'(want.vector_valid), 8'(rsp_if.vector_valid));
          check_field("irq_raised", 8'(want.irq_raised), 8'(rsp_if.irq_raised));
          if (want.irq_raised) n_raised++;
        end
      end
      rsp_if.ready <= !hold_off && ($urandom_range(99) >= snk_pct);
    end
  end

  // hold the result side off once, long enough to back up the request side
  always @(posedge clk) begin
    if (rst) begin
      hold_off   <= 1'b0;
      hold_count <= 0;
    end else if (press_on && hold_count < HOLD_CYCLES) begin
      hold_off   <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dev_master = 1'b1;
    init_st    = MODE_OCW;
    icw1_q     = 8'h00;
    vbase_q    = 8'h00;
    casc_q     = 8'h00;
    icw4_q     = 8'h00;
    imr        = MASK_ALL;
    irr        = 8'h00;
    isr        = 8'h00;
    cur_irq    = 3'd0;
    cur_vec    = 8'h00;
    cur_vec_ok = 1'b1;
    st_pend    = 1'b0;
    st_byte    = 8'h00;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = ACT_WRITE;
    req_if.addr_bit = 1'b0;
    req_if.data     = 8'h00;
    req_if.irq_line = 3'd0;
    rsp_if.ready    = 1'b0;
    src_pct         = 0;
    snk_pct         = 0;
    press_on        = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_master(1'b1);
    @(negedge clk);
    push_item(ACT_READ, 1'b0, 8'h00, 3'd0);
    push_item(ACT_READ, 1'b1, 8'h00, 3'd0);
    push_item(ACT_REQUEST, 1'b0, 8'h00, 3'd3);
    push_item(ACT_WRITE, 1'b0, 8'h11, 3'd0);
    push_item(ACT_READ, 1'b1, 8'h00, 3'd0);
    push_item(ACT_WRITE, 1'b1, 8'h20, 3'd0);
    push_item(ACT_WRITE, 1'b1, 8'h04, 3'd0);
    push_item(ACT_WRITE, 1'b1, 8'h00, 3'd0);
    push_item(ACT_WRITE, 1'b1, 8'h00, 3'd0);
    push_item(ACT_REQUEST, 1'b0, 8'h00, 3'd5);
    push_item(ACT_REQUEST, 1'b0, 8'h00, 3'd2);
    push_item(ACT_WRITE, 1'b0, 8'h0a, 3'd0);
    push_item(ACT_READ, 1'b1, 8'h00, 3'd0);
    push_item(ACT_WRITE, 1'b0, 8'h08, 3'd0);
    push_item(ACT_WRITE, 1'b0, 8'hc7, 3'd0);
    push_item(ACT_ACK, 1'b0, 8'h00, 3'd0);
    push_item(ACT_WRITE, 1'b0, 8'h20, 3'd0);
    push_item(ACT_ACK, 1'b0, 8'h00, 3'd0);
    push_item(ACT_WRITE, 1'b0, 8'h62, 3'd0);
    push_item(ACT_WRITE, 1'b0, 8'h20, 3'd0);
    push_item(ACT_WRITE, 1'b0, 8'h13, 3'd0);
    push_item(ACT_WRITE, 1'b1, 8'hff, 3'd0);
    push_item(ACT_WRITE, 1'b1, 8'h02, 3'd0);
    push_item(ACT_REQUEST, 1'b1, 8'hff, 3'd7);
    push_item(ACT_REQUEST, 1'b0, 8'h00, 3'd0);
    push_item(ACT_ACK, 1'b0, 8'h00, 3'd0);
    push_item(ACT_RESET, 1'b0, 8'h00, 3'd0);
    push_item(3'd7, 1'b1, 8'hff, 3'd7);

    run_phase(0, 0, 1'b0, 1'b0);
    run_phase(65, 0, 1'b1, 1'b0);
    run_phase(0, 65, 1'b0, 1'b0);
    run_phase(7, 7, 1'b1, 1'b0);
    run_phase(0, 0, 1'b0, 1'b1);
    run_phase(0, 0, 1'b1, 1'b0);
    wait_idle();

    $display("Sent %0d requests and checked %0d results: directed cases, then six random",
             n_req, n_rsp);
    $display("phases with idle/stall mixes, one long hold-off, master bit 0 and 1;");
    $display("%0d raised, %0d cascaded", n_raised, n_cascaded);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
